@@ rtl/dcsli_pkg.sv @@
// ----------------------------------------------------------------------------
// dcsli_pkg
// Shared constants, register indexes and control types for the dual-channel
// slope leaky integrator.
// ----------------------------------------------------------------------------
package dcsli_pkg;

    // Default sample and fraction widths.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // Gain registers are unsigned Q0.8, so every gain product shifts by eight.
    localparam int GAIN_W     = 8;
    localparam int GAIN_SHIFT = 8;

    // The clamp limit is given in whole units.
    localparam int CLAMP_W = 10;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT = 2'd2;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  RATE_GAIN_RST   = 8'd46;
    localparam logic [GAIN_W-1:0]  DECAY_GAIN_RST  = 8'd230;
    localparam logic [CLAMP_W-1:0] CLAMP_LIMIT_RST = 10'd300;

    // Commands from the controller to the channel datapaths.
    typedef struct packed {
        logic load;       // capture the input beat
        logic slope_mul;  // multiply slope error by rate gain
        logic slope_upd;  // fold the product into the slope
        logic level_mul;  // multiply level plus slope by decay gain
        logic level_upd;  // clamp and store the new level
    } dcsli_cmd_t;

    // Status seen by the controller.
    typedef struct packed {
        logic in_valid;   // an input beat is offered
        logic out_busy;   // the previous result has not been taken
    } dcsli_status_t;

endpackage

@@ rtl/dual_channel_slope_leaky_integrator.sv @@
// ----------------------------------------------------------------------------
// dual_channel_slope_leaky_integrator
// Smoothed-slope leaky integrator for an infrared and a red optical channel.
// ----------------------------------------------------------------------------
// Steps per beat: capture, slope product, slope update, decay product and level
// update; m_tvalid rises once the level is stored. Each channel's single
// multiplier serves the slope, then the decay product, each one registered.
// A stalled result holds the last step until taken; only idle takes a new beat.
// Reset (aresetn low, synchronous) zeroes previous samples, slopes, levels, and
// loads the register defaults: rate gain 46, decay gain 230, clamp limit 300.
// ----------------------------------------------------------------------------
module dual_channel_slope_leaky_integrator #(
    parameter  int SAMPLE_BITS = dcsli_pkg::SAMPLE_BITS_DEF,
    parameter  int FRAC_BITS   = dcsli_pkg::FRAC_BITS_DEF,
    localparam int LEVEL_W     = dcsli_pkg::CLAMP_W + FRAC_BITS + 1,
    localparam int IN_DATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((2 * LEVEL_W + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Input beats.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_DATA_W-1:0]                s_tdata,   // infrared_raw, red_raw
    input  logic                                s_tuser,   // sample_valid

    // Result beats.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_DATA_W-1:0]               m_tdata,   // infrared_level, red_level

    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcsli_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcsli_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dcsli_pkg::*;

    logic [GAIN_W-1:0]          rate_gain_reg;
    logic [GAIN_W-1:0]          decay_gain_reg;
    logic [CLAMP_W-1:0]         clamp_limit_reg;
    logic                       m_tvalid_reg;
    dcsli_status_t              status;
    dcsli_cmd_t                 cmd;
    logic signed [LEVEL_W-1:0]  ir_level;
    logic signed [LEVEL_W-1:0]  red_level;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_gain_reg   <= RATE_GAIN_RST;
            decay_gain_reg  <= DECAY_GAIN_RST;
            clamp_limit_reg <= CLAMP_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RATE_GAIN:   rate_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_DECAY_GAIN:  decay_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_CLAMP_LIMIT: clamp_limit_reg <= cfg_data[CLAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Controller.
    assign status.in_valid = s_tvalid;
    assign status.out_busy = m_tvalid_reg && !m_tready;

    dcsli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    // Channel datapaths.
    dcsli_chan #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_chan_ir (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .fresh_in    (s_tuser),
        .sample_in   (s_tdata[SAMPLE_BITS-1:0]),
        .rate_gain   (rate_gain_reg),
        .decay_gain  (decay_gain_reg),
        .clamp_limit (clamp_limit_reg),
        .level       (ir_level)
    );

    dcsli_chan #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_chan_red (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .fresh_in    (s_tuser),
        .sample_in   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .rate_gain   (rate_gain_reg),
        .decay_gain  (decay_gain_reg),
        .clamp_limit (clamp_limit_reg),
        .level       (red_level)
    );

    // Result beat valid. The level registers hold the data until the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.level_upd) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // Pack the result beat.
    always_comb begin
        m_tdata                        = '0;
        m_tdata[LEVEL_W-1:0]           = ir_level;
        m_tdata[2*LEVEL_W-1:LEVEL_W]   = red_level;
    end

    // Only one beat is in work at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("dcsli: input taken while a beat is in work");

    // A finished level always shows up as a result beat.
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.level_upd |=> m_tvalid)
        else $error("dcsli: level stored without a result beat");

    // A pending result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.level_upd)
        else $error("dcsli: level updated while result still pending");

endmodule

@@ rtl/dcsli_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcsli_ctrl
// Sequencer that steps both channel datapaths through the slope and level
// products of one tick.
// ----------------------------------------------------------------------------
module dcsli_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dcsli_pkg::dcsli_status_t status,
    output logic                     in_ready,
    output dcsli_pkg::dcsli_cmd_t    cmd
);
    import dcsli_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOPE_MUL,
        ST_SLOPE_UPD,
        ST_LEVEL_MUL,
        ST_LEVEL_UPD
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (status.in_valid) begin
                    state_next = ST_SLOPE_MUL;
                end
            end
            ST_SLOPE_MUL: state_next = ST_SLOPE_UPD;
            ST_SLOPE_UPD: state_next = ST_LEVEL_MUL;
            ST_LEVEL_MUL: state_next = ST_LEVEL_UPD;
            ST_LEVEL_UPD: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command decode. The level is stored only once the output side is free.
    always_comb begin
        in_ready      = (state_reg == ST_IDLE);
        cmd.load      = (state_reg == ST_IDLE) && status.in_valid;
        cmd.slope_mul = (state_reg == ST_SLOPE_MUL);
        cmd.slope_upd = (state_reg == ST_SLOPE_UPD);
        cmd.level_mul = (state_reg == ST_LEVEL_MUL);
        cmd.level_upd = (state_reg == ST_LEVEL_UPD) && !status.out_busy;
    end

    // At most one datapath step is commanded in any cycle.
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.slope_mul, cmd.slope_upd, cmd.level_mul, cmd.level_upd}))
        else $error("dcsli_ctrl: more than one datapath command active");

endmodule

@@ rtl/dcsli_chan.sv @@
// ----------------------------------------------------------------------------
// dcsli_chan
// Datapath of one channel: stored sample, slope estimate and clamped level,
// with one multiplier shared by the slope and decay products.
// ----------------------------------------------------------------------------
module dcsli_chan #(
    parameter  int SAMPLE_BITS = dcsli_pkg::SAMPLE_BITS_DEF,
    parameter  int FRAC_BITS   = dcsli_pkg::FRAC_BITS_DEF,
    localparam int LEVEL_W     = dcsli_pkg::CLAMP_W + FRAC_BITS + 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dcsli_pkg::dcsli_cmd_t               cmd,
    input  logic                                fresh_in,
    input  logic [SAMPLE_BITS-1:0]              sample_in,
    input  logic [dcsli_pkg::GAIN_W-1:0]        rate_gain,
    input  logic [dcsli_pkg::GAIN_W-1:0]        decay_gain,
    input  logic [dcsli_pkg::CLAMP_W-1:0]       clamp_limit,
    output logic signed [LEVEL_W-1:0]           level
);
    import dcsli_pkg::*;

    localparam int SLOPE_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int OPND_W  = ((SLOPE_W > LEVEL_W) ? SLOPE_W : LEVEL_W) + 1;
    localparam int PROD_W  = OPND_W + GAIN_W + 1;
    localparam int SHR_W   = PROD_W - GAIN_SHIFT;
    localparam int LIM_PAD = SHR_W - CLAMP_W - FRAC_BITS;

    logic [SAMPLE_BITS-1:0]     smp_reg;
    logic                       fresh_reg;
    logic [SAMPLE_BITS-1:0]     prev_reg;
    logic signed [SLOPE_W-1:0]  slope_reg;
    logic signed [SLOPE_W-1:0]  slope_next;
    logic signed [LEVEL_W-1:0]  accum_reg;
    logic signed [LEVEL_W-1:0]  accum_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [OPND_W-1:0]   target;
    logic signed [OPND_W-1:0]   slope_ext;
    logic signed [OPND_W-1:0]   accum_ext;
    logic signed [OPND_W-1:0]   opnd;
    logic [GAIN_W-1:0]          gain_sel;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [SHR_W-1:0]    shr;
    logic signed [SHR_W-1:0]    slope_sum;
    logic signed [SHR_W-1:0]    lim_pos;
    logic signed [SHR_W-1:0]    lim_neg;
    logic signed [SHR_W-1:0]    lvl_clamped;
    logic                       slope_hold;

    // Operand selection for the shared multiplier: slope error or level plus slope.
    always_comb begin
        diff      = $signed({1'b0, smp_reg}) - $signed({1'b0, prev_reg});
        target    = $signed({{(OPND_W - DIFF_W){diff[DIFF_W-1]}}, diff}) <<< FRAC_BITS;
        slope_ext = $signed({{(OPND_W - SLOPE_W){slope_reg[SLOPE_W-1]}}, slope_reg});
        accum_ext = $signed({{(OPND_W - LEVEL_W){accum_reg[LEVEL_W-1]}}, accum_reg});
        if (cmd.level_mul) begin
            opnd     = accum_ext + slope_ext;
            gain_sel = decay_gain;
        end else begin
            opnd     = target - slope_ext;
            gain_sel = rate_gain;
        end
        gain_s    = $signed({1'b0, gain_sel});
        prod_next = PROD_W'(opnd) * PROD_W'(gain_s);
    end

    // Floor of the registered product over 256, then slope and level updates.
    always_comb begin
        shr        = $signed(prod_reg[PROD_W-1:GAIN_SHIFT]);
        slope_sum  = $signed({{(SHR_W - SLOPE_W){slope_reg[SLOPE_W-1]}}, slope_reg}) + shr;
        slope_hold = !fresh_reg || (smp_reg == prev_reg);
        slope_next = slope_hold ? slope_reg : slope_sum[SLOPE_W-1:0];

        lim_pos = $signed({{LIM_PAD{1'b0}}, clamp_limit, {FRAC_BITS{1'b0}}});
        lim_neg = -lim_pos;
        if (shr > lim_pos) begin
            lvl_clamped = lim_pos;
        end else if (shr < lim_neg) begin
            lvl_clamped = lim_neg;
        end else begin
            lvl_clamped = shr;
        end
        accum_next = lvl_clamped[LEVEL_W-1:0];
    end

    // Beat capture and product register.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            smp_reg   <= sample_in;
            fresh_reg <= fresh_in;
        end
        if (cmd.slope_mul || cmd.level_mul) begin
            prod_reg <= prod_next;
        end
    end

    // Channel state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            slope_reg <= '0;
            accum_reg <= '0;
        end else begin
            if (cmd.slope_upd) begin
                slope_reg <= slope_next;
                if (fresh_reg) begin
                    prev_reg <= smp_reg;
                end
            end
            if (cmd.level_upd) begin
                accum_reg <= accum_next;
            end
        end
    end

    assign level = accum_reg;

    // A tick without a changed fresh sample leaves the slope alone.
    a_slope_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.slope_upd && slope_hold) |=> $stable(slope_reg))
        else $error("dcsli_chan: slope changed without a new sample");

    // The stored sample moves only in the slope update step.
    a_prev_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.slope_upd |=> $stable(prev_reg))
        else $error("dcsli_chan: stored sample changed outside its update step");

endmodule
